// ===== hw/rtl/max_pool_2d_with_gradient_core_defines.svh =====
// Assertion macros of the max pooling RTL.
// Included by mpg_engine, the module that carries concurrent checks; depends on nothing.
`ifndef MAX_POOL_2D_WITH_GRADIENT_CORE_DEFINES_SVH
`define MAX_POOL_2D_WITH_GRADIENT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MPG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpg check failed");
`define MPG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpg check failed");
`else
`define MPG_ASSERT_IMP(label, clk, rst, ante, cons)
`define MPG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/mpg_pkg.sv =====
// Shared types and constants of the max pooling core.
// Used by every module of the block but mpg_ram; depends on nothing.
`default_nettype none
package mpg_pkg;
   localparam int MAX_CHANNELS = 16;
   localparam int MAX_WIDTH    = 64;
   localparam int MAX_HEIGHT   = 64;
   localparam int MAX_WINDOW   = 8;
   localparam int CH_W   = 4;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 6;
   localparam int ADDR_W = CH_W + ROW_W + COL_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int SMP_W  = 16;
   localparam int GRD_W  = 24;
   localparam int POS_W  = 13;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_X      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_Y      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_X         = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_Y         = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd7;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE   = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_POOL = 2'd1,
      OP_GRAD = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_SCAN, ST_DRAIN, ST_GRD_RD, ST_GRD_WR, ST_GREAD, ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [CH_W-1:0]         channel;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [SMP_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] pooled_value;
      logic [ROW_W-1:0]        winner_row;
      logic [COL_W-1:0]        winner_col;
      logic                    winner_inside;
      logic signed [GRD_W-1:0] gradient;
      logic [1:0]              status;
   } rsp_type;

   // Effective settings, sizes already clamped into their legal ranges.
   typedef struct packed {
      logic [3:0] ww;
      logic [3:0] wh;
      logic [3:0] sx;
      logic [3:0] sy;
      logic [2:0] px;
      logic [2:0] py;
      logic [6:0] iw;
      logic [6:0] ih;
   } cfg_type;

   typedef struct packed {
      logic                    we;
      logic [ADDR_W-1:0]       addr;
      logic [SMP_W-1:0]        wdata;
   } smp_ram_type;

   typedef struct packed {
      logic                    we;
      logic [ADDR_W-1:0]       addr;
      logic [GRD_W-1:0]        wdata;
   } grd_ram_type;
endpackage
`default_nettype wire

// ===== hw/rtl/max_pool_2d_with_gradient_core.sv =====
// Top level of the max pooling core with gradient routing.
// Depends on mpg_pkg, mpg_csr, mpg_engine and mpg_ram.
`default_nettype none
// One request is handled at a time. A pool query reads the sample memory once per
// window position; a gradient add then does a read-modify-write of the gradient
// memory, which is skipped when the winner lies in the padding and the gradient
// is dropped. The result register frees the input side as soon as a result is
// placed in it. No clearing pass is needed: a load clears the gradient of its
// position.
module max_pool_2d_with_gradient_core
   import mpg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   cfg_type     cfg;
   smp_ram_type smp_ram;
   grd_ram_type grd_ram;
   logic [SMP_W-1:0] smp_rdata;
   logic [GRD_W-1:0] grd_rdata;

   // Configuration registers.
   mpg_csr u_csr (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .cfg
   );

   // Sequencer and datapath.
   mpg_engine u_engine (
      .clock, .reset, .cfg,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .smp_ram, .smp_rdata, .grd_ram, .grd_rdata
   );

   // Sample memory.
   mpg_ram #(.WIDTH(SMP_W), .DEPTH(DEPTH)) u_smp_ram (
      .clock, .we(smp_ram.we), .addr(smp_ram.addr), .wdata(smp_ram.wdata),
      .rdata(smp_rdata)
   );

   // Gradient memory.
   mpg_ram #(.WIDTH(GRD_W), .DEPTH(DEPTH)) u_grd_ram (
      .clock, .we(grd_ram.we), .addr(grd_ram.addr), .wdata(grd_ram.wdata),
      .rdata(grd_rdata)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/mpg_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module mpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and read-first registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mpg_csr.sv =====
// Configuration registers of the pooling core and their clamped view.
// Depends on mpg_pkg.
`default_nettype none
module mpg_csr
   import mpg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);
   logic [3:0] ww_ff, wh_ff, sx_ff, sy_ff;
   logic [2:0] px_ff, py_ff;
   logic [6:0] iw_ff, ih_ff;

   // Register writes by index; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         ww_ff <= 4'd2;
         wh_ff <= 4'd2;
         sx_ff <= 4'd2;
         sy_ff <= 4'd2;
         px_ff <= 3'd0;
         py_ff <= 3'd0;
         iw_ff <= 7'd64;
         ih_ff <= 7'd64;
      end else if (csr_we) begin
         case (csr_index)
            REG_WINDOW_WIDTH:  ww_ff <= csr_wdata[3:0];
            REG_WINDOW_HEIGHT: wh_ff <= csr_wdata[3:0];
            REG_STRIDE_X:      sx_ff <= csr_wdata[3:0];
            REG_STRIDE_Y:      sy_ff <= csr_wdata[3:0];
            REG_PAD_X:         px_ff <= csr_wdata[2:0];
            REG_PAD_Y:         py_ff <= csr_wdata[2:0];
            REG_IMAGE_WIDTH:   iw_ff <= csr_wdata[6:0];
            REG_IMAGE_HEIGHT:  ih_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Sizes of zero act as one, sizes above the maximum act as the maximum.
   always_comb begin
      cfg.ww = (ww_ff == 4'd0) ? 4'd1 :
               ({28'd0, ww_ff} > MAX_WINDOW) ? 4'(MAX_WINDOW) : ww_ff;
      cfg.wh = (wh_ff == 4'd0) ? 4'd1 :
               ({28'd0, wh_ff} > MAX_WINDOW) ? 4'(MAX_WINDOW) : wh_ff;
      cfg.iw = (iw_ff == 7'd0) ? 7'd1 :
               ({25'd0, iw_ff} > MAX_WIDTH) ? 7'(MAX_WIDTH) : iw_ff;
      cfg.ih = (ih_ff == 7'd0) ? 7'd1 :
               ({25'd0, ih_ff} > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : ih_ff;
      cfg.sx = sx_ff;
      cfg.sy = sy_ff;
      cfg.px = px_ff;
      cfg.py = py_ff;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mpg_engine.sv =====
// Sequencer and datapath: window scan over the sample memory and
// read-modify-write of the gradient memory. Depends on mpg_pkg and the defines.
`default_nettype none
`include "max_pool_2d_with_gradient_core_defines.svh"
module mpg_engine
   import mpg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   output smp_ram_type           smp_ram,
   input  wire logic [SMP_W-1:0] smp_rdata,
   output grd_ram_type           grd_ram,
   input  wire logic [GRD_W-1:0] grd_rdata
);
   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic signed [POS_W-1:0] y0_ff, y0_in, x0_ff, x0_in;
   logic [3:0] ci_ff, ci_in, cj_ff, cj_in;
   logic p_vld_ff, p_vld_in, p_in_ff, p_in_in;
   logic [ROW_W-1:0] p_y_ff, p_y_in;
   logic [COL_W-1:0] p_x_ff, p_x_in;
   logic have_ff, have_in;
   logic signed [SMP_W-1:0] best_ff, best_in;
   logic [ROW_W-1:0] win_row_ff, win_row_in;
   logic [COL_W-1:0] win_col_ff, win_col_in;
   logic win_in_ff, win_in_in;
   logic signed [GRD_W-1:0] grad_ff, grad_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept, out_free, last_pos, bad_ch, outside, in_img;
   logic [9:0] row_mul, col_mul;
   logic signed [POS_W-1:0] y_pos, x_pos;
   logic signed [SMP_W-1:0] cand;
   logic signed [GRD_W:0] sum;
   logic [ADDR_W-1:0] req_addr;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Window origin, current scan position and its image membership.
   always_comb begin
      row_mul = 10'(req_data.row) * 10'(cfg.sy);
      col_mul = 10'(req_data.col) * 10'(cfg.sx);
      y_pos   = y0_ff + $signed({9'd0, ci_ff});
      x_pos   = x0_ff + $signed({9'd0, cj_ff});
      in_img  = !y_pos[POS_W-1] && !x_pos[POS_W-1] &&
                (y_pos < $signed({6'd0, cfg.ih})) && (x_pos < $signed({6'd0, cfg.iw}));
      last_pos = (ci_ff == cfg.wh - 4'd1) && (cj_ff == cfg.ww - 4'd1);
      bad_ch   = ({1'b0, req_ff.channel} >= 5'(MAX_CHANNELS));
      outside  = ({1'b0, req_ff.row} >= cfg.ih) || ({1'b0, req_ff.col} >= cfg.iw);
      req_addr = {req_ff.channel, req_ff.row, req_ff.col};
      cand     = p_in_ff ? $signed(smp_rdata) : '0;
      sum      = $signed({grd_rdata[GRD_W-1], grd_rdata}) +
                 $signed({{(GRD_W-SMP_W+1){req_ff.value[SMP_W-1]}}, req_ff.value});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_START;
         ST_START: begin
            if (bad_ch) begin
               state_in = ST_DONE;
            end else begin
               case (op_type'(req_ff.opcode))
                  OP_LOAD: state_in = ST_DONE;
                  OP_READ: state_in = outside ? ST_DONE : ST_GREAD;
                  default: state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN:   if (last_pos) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = (req_ff.opcode == OP_GRAD) ? ST_GRD_RD : ST_DONE;
         ST_GRD_RD: state_in = win_in_ff ? ST_GRD_WR : ST_DONE;
         ST_GRD_WR: state_in = ST_DONE;
         ST_GREAD:  state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory commands and result register.
   always_comb begin
      req_in = req_ff;
      y0_in = y0_ff;  x0_in = x0_ff;
      ci_in = ci_ff;  cj_in = cj_ff;
      p_vld_in = 1'b0; p_in_in = p_in_ff; p_y_in = p_y_ff; p_x_in = p_x_ff;
      have_in = have_ff; best_in = best_ff;
      win_row_in = win_row_ff; win_col_in = win_col_ff; win_in_in = win_in_ff;
      grad_in = grad_ff; status_in = status_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      smp_ram = '{we: 1'b0, addr: {req_ff.channel, y_pos[ROW_W-1:0], x_pos[COL_W-1:0]},
                  wdata: req_ff.value};
      grd_ram = '{we: 1'b0, addr: req_addr, wdata: '0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               y0_in  = $signed({3'd0, row_mul}) - $signed({10'd0, cfg.py});
               x0_in  = $signed({3'd0, col_mul}) - $signed({10'd0, cfg.px});
            end
         end
         ST_START: begin
            ci_in = '0; cj_in = '0; have_in = 1'b0; best_in = '0;
            win_row_in = '0; win_col_in = '0; win_in_in = 1'b0;
            grad_in = '0; status_in = STATUS_OK;
            if (bad_ch) begin
               status_in = STATUS_OUTSIDE;
            end else if ((req_ff.opcode == OP_LOAD) || (req_ff.opcode == OP_READ)) begin
               if (outside) begin
                  status_in = STATUS_OUTSIDE;
               end else if (req_ff.opcode == OP_LOAD) begin
                  // A new sample starts its gradient from zero.
                  smp_ram.we   = 1'b1;
                  smp_ram.addr = req_addr;
                  grd_ram.we   = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            p_vld_in = 1'b1;
            p_in_in  = in_img;
            p_y_in   = y_pos[ROW_W-1:0];
            p_x_in   = x_pos[COL_W-1:0];
            if (cj_ff == cfg.ww - 4'd1) begin
               cj_in = '0;
               ci_in = ci_ff + 4'd1;
            end else begin
               cj_in = cj_ff + 4'd1;
            end
         end
         ST_GRD_RD: begin
            grd_ram.addr = {req_ff.channel, win_row_ff, win_col_ff};
         end
         ST_GRD_WR: begin
            grd_ram.addr = {req_ff.channel, win_row_ff, win_col_ff};
            grd_ram.we   = 1'b1;
            // Saturate the accumulated gradient to its 24-bit range.
            if (sum > $signed(25'h07FFFFF)) begin
               grad_in = 24'h7FFFFF;  status_in = STATUS_SATURATED;
            end else if (sum < $signed(25'h1800000)) begin
               grad_in = 24'h800000;  status_in = STATUS_SATURATED;
            end else begin
               grad_in = sum[GRD_W-1:0];
            end
            grd_ram.wdata = grad_in;
         end
         ST_GREAD: begin
            grad_in = $signed(grd_rdata);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{pooled_value: best_ff, winner_row: win_row_ff,
                          winner_col: win_col_ff, winner_inside: win_in_ff,
                          gradient: grad_ff, status: status_ff};
            end
         end
         default: ;
      endcase

      // Compare stage: the sample read last cycle against the running maximum.
      if (p_vld_ff && (!have_ff || (cand > best_ff))) begin
         have_in    = 1'b1;
         best_in    = cand;
         win_in_in  = p_in_ff;
         win_row_in = p_in_ff ? p_y_ff : '0;
         win_col_in = p_in_ff ? p_x_ff : '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         p_vld_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p_vld_ff     <= p_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      y0_ff <= y0_in;  x0_ff <= x0_in;
      ci_ff <= ci_in;  cj_ff <= cj_in;
      p_in_ff <= p_in_in; p_y_ff <= p_y_in; p_x_ff <= p_x_in;
      have_ff <= have_in; best_ff <= best_in;
      win_row_ff <= win_row_in; win_col_ff <= win_col_in; win_in_ff <= win_in_in;
      grad_ff <= grad_in; status_ff <= status_in;
      rsp_ff <= rsp_in;
   end

   `MPG_ASSERT_IMP(a_load_pair, clock, reset, smp_ram.we, grd_ram.we && (grd_ram.wdata == '0))
   `MPG_ASSERT_NXT(a_rmw_order, clock, reset, state_ff == ST_GRD_RD && win_in_ff, state_ff == ST_GRD_WR)
   `MPG_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == ST_SCAN, (cj_ff < cfg.ww) && (ci_ff < cfg.wh))
   `MPG_ASSERT_IMP(a_pad_winner, clock, reset, state_ff == ST_DONE && !win_in_ff, (win_row_ff == '0) && (win_col_ff == '0))
endmodule
`default_nettype wire

// ===== dv/tb_max_pool_2d_with_gradient_core.sv =====
// Self-checking testbench of the max pooling core with gradient routing.
// Depends on mpg_pkg and max_pool_2d_with_gradient_core; predicts every response itself.
`default_nettype none
module tb_max_pool_2d_with_gradient_core;
   import mpg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 100;
   localparam int IDLE_LIMIT    = 3000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   max_pool_2d_with_gradient_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the block's images and registers.
   logic signed [SMP_W-1:0] sample_img [DEPTH];
   logic signed [GRD_W-1:0] grad_img [DEPTH];
   bit                      sample_known [DEPTH];
   bit [6:0]                cfg_reg [8];
   rsp_type                 pending_rsp [$];
   int                      error_count = 0;
   int                      burst_left = 0;
   int                      loaded_ch;

   function automatic int clamp_size(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // True when every in-image position of the window has been loaded.
   function automatic bit window_known(logic [3:0] ch, int orow, int ocol);
      int ww, wh, iw, ih, y, x;
      ww = clamp_size(cfg_reg[REG_WINDOW_WIDTH], MAX_WINDOW);
      wh = clamp_size(cfg_reg[REG_WINDOW_HEIGHT], MAX_WINDOW);
      iw = clamp_size(cfg_reg[REG_IMAGE_WIDTH], MAX_WIDTH);
      ih = clamp_size(cfg_reg[REG_IMAGE_HEIGHT], MAX_HEIGHT);
      for (int i = 0; i < wh; i++) begin
         for (int j = 0; j < ww; j++) begin
            y = orow * int'(cfg_reg[REG_STRIDE_Y]) - int'(cfg_reg[REG_PAD_Y]) + i;
            x = ocol * int'(cfg_reg[REG_STRIDE_X]) - int'(cfg_reg[REG_PAD_X]) + j;
            if (y >= 0 && y < ih && x >= 0 && x < iw && !sample_known[{ch, y[5:0], x[5:0]}])
               return 0;
         end
      end
      return 1;
   endfunction

   // Computes the response of one request and updates the shadow images.
   function automatic rsp_type compute_response(req_type rq);
      rsp_type    rs;
      int         iw, ih, ww, wh, y0, x0, y, x, best, v, sum;
      bit         have, ins;
      logic [15:0] k;
      rs = '0;
      iw = clamp_size(cfg_reg[REG_IMAGE_WIDTH], MAX_WIDTH);
      ih = clamp_size(cfg_reg[REG_IMAGE_HEIGHT], MAX_HEIGHT);
      if (rq.channel >= MAX_CHANNELS) begin
         rs.status = STATUS_OUTSIDE;
      end else if (op_type'(rq.opcode) == OP_LOAD || op_type'(rq.opcode) == OP_READ) begin
         if (rq.row >= ih || rq.col >= iw) begin
            rs.status = STATUS_OUTSIDE;
         end else begin
            k = {rq.channel, rq.row, rq.col};
            if (op_type'(rq.opcode) == OP_LOAD) begin
               sample_img[k] = rq.value;
               grad_img[k] = '0;
               sample_known[k] = 1'b1;
            end else begin
               rs.gradient = grad_img[k];
            end
         end
      end else begin
         ww = clamp_size(cfg_reg[REG_WINDOW_WIDTH], MAX_WINDOW);
         wh = clamp_size(cfg_reg[REG_WINDOW_HEIGHT], MAX_WINDOW);
         y0 = int'(rq.row) * int'(cfg_reg[REG_STRIDE_Y]) - int'(cfg_reg[REG_PAD_Y]);
         x0 = int'(rq.col) * int'(cfg_reg[REG_STRIDE_X]) - int'(cfg_reg[REG_PAD_X]);
         best = 0;
         have = 0;
         // Row-major scan; only a strictly larger value takes over.
         for (int i = 0; i < wh; i++) begin
            for (int j = 0; j < ww; j++) begin
               y = y0 + i;
               x = x0 + j;
               ins = (y >= 0 && y < ih && x >= 0 && x < iw);
               if (ins) v = sample_img[{rq.channel, y[5:0], x[5:0]}];
               else v = 0;
               if (!have || v > best) begin
                  have = 1;
                  best = v;
                  rs.winner_inside = ins;
                  rs.winner_row = ins ? y[5:0] : '0;
                  rs.winner_col = ins ? x[5:0] : '0;
               end
            end
         end
         rs.pooled_value = best[15:0];
         // A padded winner drops the gradient.
         if (op_type'(rq.opcode) == OP_GRAD && rs.winner_inside) begin
            k = {rq.channel, rs.winner_row, rs.winner_col};
            sum = int'(grad_img[k]) + int'(rq.value);
            if (sum > 8388607) begin
               sum = 8388607;
               rs.status = STATUS_SATURATED;
            end
            if (sum < -8388608) begin
               sum = -8388608;
               rs.status = STATUS_SATURATED;
            end
            grad_img[k] = sum[23:0];
            rs.gradient = sum[23:0];
         end
      end
      return rs;
   endfunction

   // Sends one request in bursts separated by random gaps.
   task automatic send_request(req_type rq);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(compute_response(rq));
      burst_left--;
   endtask

   task automatic send_fields(op_type op, int ch, int r, int c, int val);
      req_type rq;
      rq.opcode = op;
      rq.channel = ch[3:0];
      rq.row = r[5:0];
      rq.col = c[5:0];
      rq.value = val[15:0];
      send_request(rq);
   endtask

   // Lets the block go idle: no pending response and no work in flight.
   task automatic wait_idle(int settle);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic apply_config(int ww, int wh, int sx, int sy, int px, int py, int iw, int ih);
      int vals [8];
      bit [6:0] masks [8];
      vals = '{ww, wh, sx, sy, px, py, iw, ih};
      masks = '{7'hF, 7'hF, 7'hF, 7'hF, 7'h7, 7'h7, 7'h7F, 7'h7F};
      wait_idle(SETTLE_CYCLES);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= i[CSR_IDX_W-1:0];
         csr_wdata <= vals[i][6:0];
         cfg_reg[i] = vals[i][6:0] & masks[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic load_image(int ch);
      int iw, ih;
      iw = clamp_size(cfg_reg[REG_IMAGE_WIDTH], MAX_WIDTH);
      ih = clamp_size(cfg_reg[REG_IMAGE_HEIGHT], MAX_HEIGHT);
      for (int r = 0; r < ih; r++)
         for (int c = 0; c < iw; c++)
            send_fields(OP_LOAD, ch, r, c,
                        $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 9));
   endtask

   // Reset settings: ties, extreme samples, every opcode, a window wholly in padding.
   task automatic test_reset_settings();
      int vals [16];
      vals = '{5, 5, -32768, 32767, -1, -1, -2, 0, 32767, 100, 32767, -32768, 0, 0, 0, 0};
      for (int i = 0; i < 16; i++) send_fields(OP_LOAD, 0, i / 4, i % 4, vals[i]);
      send_fields(OP_POOL, 0, 0, 0, 0);
      send_fields(OP_POOL, 0, 0, 1, 0);
      send_fields(OP_POOL, 0, 1, 0, 0);
      send_fields(OP_POOL, 0, 1, 1, 0);
      send_fields(OP_GRAD, 0, 0, 0, -32768);
      send_fields(OP_GRAD, 0, 1, 1, 32767);
      send_fields(OP_READ, 0, 0, 1, 0);
      send_fields(OP_READ, 0, 2, 2, 0);
      send_fields(OP_POOL, 15, 63, 63, 0);
      send_fields(OP_GRAD, 15, 63, 63, 32767);
   endtask

   // Out-of-range register values, zero strides, one-wide and one-high images.
   task automatic test_extreme_settings();
      apply_config(0, 15, 0, 15, 7, 7, 0, 127);
      for (int r = 0; r < 64; r++) send_fields(OP_LOAD, 3, r, 0, $urandom_range(0, 65535));
      for (int i = 0; i < 6; i++) send_fields(OP_POOL, 3, i, $urandom_range(0, 63), 0);
      send_fields(OP_LOAD, 3, 0, 1, 7);
      send_fields(OP_READ, 3, 5, 63, 0);
      apply_config(15, 0, 15, 0, 0, 0, 127, 0);
      for (int c = 0; c < 64; c++) send_fields(OP_LOAD, 4, 0, c, $urandom_range(0, 65535));
      for (int i = 0; i < 6; i++) begin
         send_fields(OP_POOL, 4, $urandom_range(0, 63), i, 0);
         send_fields(OP_GRAD, 4, 0, i, $urandom_range(0, 65535));
      end
      send_fields(OP_READ, 4, 1, 0, 0);
      send_fields(OP_READ, 4, 0, 3, 0);
   endtask

   // Drives one gradient to the positive clamp and another to the negative clamp.
   task automatic test_saturation();
      apply_config(1, 1, 1, 1, 0, 0, 4, 4);
      send_fields(OP_LOAD, 5, 0, 0, 100);
      send_fields(OP_LOAD, 5, 0, 1, -100);
      repeat (257) send_fields(OP_GRAD, 5, 0, 0, 32767);
      send_fields(OP_READ, 5, 0, 0, 0);
      repeat (257) send_fields(OP_GRAD, 5, 0, 1, -32768);
      send_fields(OP_READ, 5, 0, 1, 0);
   endtask

   // Random mix over several settings; requests touching unloaded data are redrawn or become loads.
   task automatic test_random_mix();
      int settings [6][8];
      int iw, ih, sy, sx, pick, r, c;
      req_type rq;
      bit ok;
      settings = '{'{2, 2, 2, 2, 0, 0, 6, 6}, '{3, 3, 1, 1, 1, 1, 7, 5},
                   '{8, 8, 8, 8, 7, 7, 8, 8}, '{1, 1, 1, 1, 0, 0, 5, 4},
                   '{4, 2, 3, 1, 2, 0, 8, 3}, '{8, 1, 0, 3, 3, 5, 2, 8}};
      for (int p = 0; p < 6; p++) begin
         apply_config(settings[p][0], settings[p][1], settings[p][2], settings[p][3],
                      settings[p][4], settings[p][5], settings[p][6], settings[p][7]);
         loaded_ch = $urandom_range(0, 15);
         load_image(loaded_ch);
         iw = clamp_size(cfg_reg[REG_IMAGE_WIDTH], MAX_WIDTH);
         ih = clamp_size(cfg_reg[REG_IMAGE_HEIGHT], MAX_HEIGHT);
         sx = (cfg_reg[REG_STRIDE_X] == 0) ? 1 : cfg_reg[REG_STRIDE_X];
         sy = (cfg_reg[REG_STRIDE_Y] == 0) ? 1 : cfg_reg[REG_STRIDE_Y];
         for (int n = 0; n < 40; n++) begin
            // Hold off once until the block has answered everything.
            if (p == 2 && n == 20) wait_idle(0);
            ok = 0;
            for (int tries = 0; tries < 40 && !ok; tries++) begin
               pick = $urandom_range(0, 99);
               rq.opcode = (pick < 20) ? OP_LOAD : (pick < 55) ? OP_POOL
                         : (pick < 85) ? OP_GRAD : OP_READ;
               rq.channel = ($urandom_range(0, 99) < 85) ? loaded_ch[3:0]
                                                          : $urandom_range(0, 15);
               rq.value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 65535);
               if (op_type'(rq.opcode) == OP_LOAD || op_type'(rq.opcode) == OP_READ) begin
                  if ($urandom_range(0, 99) < 85) begin
                     r = $urandom_range(0, ih - 1);
                     c = $urandom_range(0, iw - 1);
                  end else begin
                     r = $urandom_range(0, 63);
                     c = $urandom_range(0, 63);
                  end
               end else if ($urandom_range(0, 99) < 85) begin
                  r = $urandom_range(0, (ih + cfg_reg[REG_PAD_Y]) / sy + 1);
                  c = $urandom_range(0, (iw + cfg_reg[REG_PAD_X]) / sx + 1);
               end else begin
                  r = $urandom_range(0, 63);
                  c = $urandom_range(0, 63);
               end
               rq.row = r[5:0];
               rq.col = c[5:0];
               case (op_type'(rq.opcode))
                  OP_LOAD: ok = 1;
                  OP_READ: ok = (r >= ih || c >= iw || sample_known[{rq.channel, rq.row, rq.col}]);
                  default: ok = window_known(rq.channel, r, c);
               endcase
            end
            if (!ok) rq.opcode = OP_LOAD;
            send_request(rq);
         end
      end
   endtask

   // Receiver stall pattern, switching between none, random and periodic.
   int stall_tick = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      stall_tick++;
      if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 40);
         default: rsp_stall <= (stall_tick % 7 < 3);
      endcase
   end

   task automatic report_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // Response checker against the oldest prediction.
   rsp_type exp_rsp;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response %h expected none", $realtime, rsp_data);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            report_field("pooled_value", exp_rsp.pooled_value, rsp_data.pooled_value);
            report_field("winner_row", exp_rsp.winner_row, rsp_data.winner_row);
            report_field("winner_col", exp_rsp.winner_col, rsp_data.winner_col);
            report_field("winner_inside", exp_rsp.winner_inside, rsp_data.winner_inside);
            report_field("gradient", exp_rsp.gradient, rsp_data.gradient);
            report_field("status", exp_rsp.status, rsp_data.status);
         end
      end
   end

   // Watchdog on cycles without any handshake.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      cfg_reg = '{7'd2, 7'd2, 7'd2, 7'd2, 7'd0, 7'd0, 7'd64, 7'd64};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_extreme_settings();
      test_saturation();
      test_random_mix();
      wait_idle(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mpg_pkg.sv
hw/rtl/mpg_ram.sv
hw/rtl/mpg_csr.sv
hw/rtl/mpg_engine.sv
hw/rtl/max_pool_2d_with_gradient_core.sv
dv/tb_max_pool_2d_with_gradient_core.sv
